FILE: rtl/core/cbf_pkg.sv
// Shared types and constants for the cubic Bezier flattener.
`timescale 1ns / 1ps
package cbf_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int MAX_POINTS_DEF  = 64;
  localparam int RES_W           = 16;
  localparam int T_W             = 17;    // t in Q0.16 plus a bit to hold 1.0
  localparam logic [RES_W-1:0] RES_RESET = 16'd256;

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] start_x;
    logic signed [COORD_WIDTH_DEF-1:0] start_y;
    logic signed [COORD_WIDTH_DEF-1:0] ctrl1_x;
    logic signed [COORD_WIDTH_DEF-1:0] ctrl1_y;
    logic signed [COORD_WIDTH_DEF-1:0] ctrl2_x;
    logic signed [COORD_WIDTH_DEF-1:0] ctrl2_y;
    logic signed [COORD_WIDTH_DEF-1:0] end_x;
    logic signed [COORD_WIDTH_DEF-1:0] end_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] point_x;
    logic signed [COORD_WIDTH_DEF-1:0] point_y;
    logic                              last_point;
  } out_beat_t;

  // Datapath operations requested by the controller.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_SQRT   = 3'd2,
    OP_DIV    = 3'd3,
    OP_WEIGHT = 3'd4,
    OP_ACC    = 3'd5,
    OP_EMIT   = 3'd6,
    OP_END    = 3'd7
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       first;    // first cycle of a multi-cycle op
  } dp_cmd_t;

  typedef struct packed {
    logic       done;       // multi-cycle op finished
    logic       chord_zero;
    logic       t_more;     // next t is below one and point budget remains
  } dp_stat_t;

endpackage

FILE: rtl/core/cbf_datapath.sv
// Datapath: chord root, step divide, Bernstein weights and point accumulate.
`timescale 1ns / 1ps
module cbf_datapath #(
  parameter int MAX_POINTS  = cbf_pkg::MAX_POINTS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  cbf_pkg::in_beat_t                           in_beat,
  input  logic [cbf_pkg::RES_W-1:0]                   step_res,
  input  cbf_pkg::dp_cmd_t                            cmd,
  output cbf_pkg::dp_stat_t                           stat,
  output logic signed [cbf_pkg::COORD_WIDTH_DEF-1:0]  pt_x,
  output logic signed [cbf_pkg::COORD_WIDTH_DEF-1:0]  pt_y
);
  import cbf_pkg::*;

  localparam int CW      = COORD_WIDTH_DEF;
  localparam int DIFF_W  = 23;                 // capped magnitude up to 2^22
  localparam int SQ_W    = 2 * DIFF_W + 2;     // sum of squares
  localparam int ROOT_W  = SQ_W / 2;
  localparam int NUM_W   = RES_W + 16;
  localparam int QUO_W   = NUM_W;
  localparam int MIN_STEP = (65536 + MAX_POINTS - 1) / MAX_POINTS;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int SQ_CW   = $clog2(ROOT_W + 1);
  localparam int DV_CW   = $clog2(QUO_W + 1);
  localparam int ACC_W   = 64;
  localparam logic [DIFF_W-1:0] CAP = DIFF_W'(1 << 22);

  // Control points latched at load, at the input coordinate width.
  logic signed [CW-1:0] px_r [4];
  logic signed [CW-1:0] py_r [4];

  // Square-root and divide registers; the root also serves as the divisor.
  logic [SQ_W-1:0]   rem_r, rem_nxt;
  logic [SQ_W-1:0]   rad_r;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [SQ_CW-1:0]  sq_cnt_r;
  logic [NUM_W-1:0]  num_r;
  logic [QUO_W-1:0]  quo_r;
  logic [DIFF_W+1:0] drem_r;
  logic [DV_CW-1:0]  dv_cnt_r;

  logic [T_W-1:0]    step_r;
  logic [T_W-1:0]    t_r;
  logic [CNT_W-1:0]  n_r;

  // Weight pipeline: products registered between multiplications.
  logic [2:0]        wph_r;
  logic [33:0]       uu_r, tt_r;
  logic [24:0]       w_r [4];
  logic [1:0]        ai_r;
  logic [2:0]        acc_ph_r;
  logic signed [ACC_W-1:0] ax_r, ay_r;
  logic signed [CW-1:0] ox_r, oy_r;

  function automatic logic [DIFF_W-1:0] mag_cap(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    logic [CW:0]        m;
    d = {b[CW-1], b} - {a[CW-1], a};
    m = d[CW] ? (CW+1)'(-d) : (CW+1)'(d);
    if (m > (CW+1)'(CAP)) mag_cap = CAP;
    else mag_cap = DIFF_W'(m);
  endfunction

  function automatic logic signed [CW-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] hi, lo;
    r  = (a + ACC_W'(64'sd1 <<< 23)) >>> 24;
    hi = ACC_W'((64'sd1 <<< (CW - 1)) - 1);
    lo = -hi - 1;
    if (r > hi) round_sat = CW'(hi);
    else if (r < lo) round_sat = CW'(lo);
    else round_sat = CW'(r);
  endfunction

  logic [DIFF_W-1:0] dx, dy;
  logic [2*DIFF_W-1:0] dx2, dy2;
  assign dx  = mag_cap(in_beat.start_x, in_beat.end_x);
  assign dy  = mag_cap(in_beat.start_y, in_beat.end_y);
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;

  // Bit-pair restoring square root: one result bit per cycle.
  logic [SQ_W-1:0] trial;
  always_comb begin
    trial    = {rem_r[SQ_W-3:0], rad_r[SQ_W-1 -: 2]};
    rem_nxt  = trial;
    root_nxt = {root_r[ROOT_W-2:0], 1'b0};
    if (trial >= SQ_W'({root_r, 2'b01})) begin
      rem_nxt  = trial - SQ_W'({root_r, 2'b01});
      root_nxt = {root_r[ROOT_W-2:0], 1'b1};
    end
  end

  // Restoring divide: one quotient bit per cycle.
  logic [DIFF_W+1:0] dtrial;
  logic [ROOT_W:0]   dsh;
  assign dsh    = {drem_r[DIFF_W:0], num_r[NUM_W-1]};
  assign dtrial = (DIFF_W+2)'(dsh);

  logic [T_W-1:0] u_val, t_next;
  logic [T_W:0]   t_sum;
  assign u_val = T_W'(17'h10000) - t_r;
  assign t_sum = {1'b0, t_r} + {1'b0, step_r};
  assign t_next = t_sum[T_W-1:0];

  // Weight product selection per pipeline phase (one 34x17 multiplier).
  logic [33:0] mul_a;
  logic [16:0] mul_b;
  logic [50:0] mul_p;
  logic [50:0] w3u;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (wph_r)
      3'd0: begin mul_a = 34'(u_val); mul_b = u_val; end
      3'd1: begin mul_a = 34'(t_r);   mul_b = t_r;   end
      3'd2: begin mul_a = uu_r;       mul_b = u_val; end
      3'd3: begin mul_a = uu_r;       mul_b = t_r;   end
      3'd4: begin mul_a = tt_r;       mul_b = u_val; end
      3'd5: begin mul_a = tt_r;       mul_b = t_r;   end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;
  assign w3u   = (mul_p << 1) + mul_p;

  logic [50:0] wround;
  assign wround = ((wph_r == 3'd3 || wph_r == 3'd4) ? w3u : mul_p) + 51'(1 << 23);

  logic signed [CW-1:0] ax_pt, ay_pt;
  logic signed [25+CW:0] prod_x, prod_y;
  assign ax_pt  = px_r[ai_r];
  assign ay_pt  = py_r[ai_r];
  assign prod_x = $signed({1'b0, w_r[ai_r]}) * ax_pt;
  assign prod_y = $signed({1'b0, w_r[ai_r]}) * ay_pt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_cnt_r <= '0;
      dv_cnt_r <= '0;
      wph_r    <= '0;
      acc_ph_r <= '0;
      n_r      <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          px_r[0] <= in_beat.start_x; py_r[0] <= in_beat.start_y;
          px_r[1] <= in_beat.ctrl1_x; py_r[1] <= in_beat.ctrl1_y;
          px_r[2] <= in_beat.ctrl2_x; py_r[2] <= in_beat.ctrl2_y;
          px_r[3] <= in_beat.end_x;   py_r[3] <= in_beat.end_y;
          rad_r    <= SQ_W'(dx2) + SQ_W'(dy2);
          rem_r    <= '0;
          root_r   <= '0;
          sq_cnt_r <= SQ_CW'(ROOT_W);
          n_r      <= '0;
        end
        OP_SQRT: begin
          rem_r    <= rem_nxt;
          root_r   <= root_nxt;
          rad_r    <= {rad_r[SQ_W-3:0], 2'b00};
          sq_cnt_r <= sq_cnt_r - 1'b1;
          if (cmd.first) begin
            num_r    <= {step_res, 16'h0000};
            drem_r   <= '0;
            dv_cnt_r <= DV_CW'(QUO_W);
            quo_r    <= '0;
          end
        end
        OP_DIV: begin
          if (cmd.first) begin
            num_r    <= {step_res, 16'h0000};
            drem_r   <= '0;
            dv_cnt_r <= DV_CW'(QUO_W);
            quo_r    <= '0;
          end else begin
            num_r    <= {num_r[NUM_W-2:0], 1'b0};
            dv_cnt_r <= dv_cnt_r - 1'b1;
            if (dtrial >= (DIFF_W+2)'(root_r)) begin
              drem_r <= dtrial - (DIFF_W+2)'(root_r);
              quo_r  <= {quo_r[QUO_W-2:0], 1'b1};
            end else begin
              drem_r <= dtrial;
              quo_r  <= {quo_r[QUO_W-2:0], 1'b0};
            end
          end
        end
        OP_WEIGHT: begin
          if (cmd.first) wph_r <= '0;
          else begin
            case (wph_r)
              3'd0: uu_r <= 34'(mul_p);
              3'd1: tt_r <= 34'(mul_p);
              3'd2: w_r[0] <= 25'(wround >> 24);
              3'd3: w_r[1] <= 25'(wround >> 24);
              3'd4: w_r[2] <= 25'(wround >> 24);
              3'd5: w_r[3] <= 25'(wround >> 24);
              default: ;
            endcase
            wph_r <= wph_r + 1'b1;
          end
        end
        OP_ACC: begin
          if (cmd.first) begin
            ai_r     <= '0;
            acc_ph_r <= '0;
            ax_r     <= '0;
            ay_r     <= '0;
          end else begin
            ax_r     <= ax_r + ACC_W'(prod_x);
            ay_r     <= ay_r + ACC_W'(prod_y);
            ai_r     <= ai_r + 1'b1;
            acc_ph_r <= acc_ph_r + 1'b1;
          end
        end
        OP_EMIT: begin
          ox_r <= round_sat(ax_r);
          oy_r <= round_sat(ay_r);
          t_r  <= t_next;
          n_r  <= n_r + 1'b1;
        end
        OP_END: begin
          ox_r <= px_r[3];
          oy_r <= py_r[3];
        end
        OP_NONE: ;
        default: ;
      endcase
      // final quotient lands after the last divide cycle
      if (cmd.op == OP_DIV && !cmd.first && dv_cnt_r == DV_CW'(1)) begin
        if ({quo_r[QUO_W-2:0], dtrial >= (DIFF_W+2)'(root_r)} < QUO_W'(MIN_STEP)) begin
          step_r <= T_W'(MIN_STEP);
          t_r    <= T_W'(MIN_STEP);
        end else if ({quo_r[QUO_W-2:0], dtrial >= (DIFF_W+2)'(root_r)}
                     >= QUO_W'(32'h10000)) begin
          step_r <= T_W'(17'h10000);
          t_r    <= T_W'(17'h10000);
        end else begin
          step_r <= T_W'({quo_r[QUO_W-2:0], dtrial >= (DIFF_W+2)'(root_r)});
          t_r    <= T_W'({quo_r[QUO_W-2:0], dtrial >= (DIFF_W+2)'(root_r)});
        end
      end
    end
  end

  always_comb begin
    stat.done = 1'b0;
    case (cmd.op)
      OP_SQRT:   stat.done = (sq_cnt_r == SQ_CW'(1));
      OP_DIV:    stat.done = !cmd.first && (dv_cnt_r == DV_CW'(1));
      OP_WEIGHT: stat.done = !cmd.first && (wph_r == 3'd5);
      OP_ACC:    stat.done = !cmd.first && (acc_ph_r == 3'd3);
      default:   stat.done = 1'b0;
    endcase
  end
  assign stat.chord_zero = (root_r == '0);
  assign stat.t_more     = (t_r < T_W'(17'h10000)) && (n_r < CNT_W'(MAX_POINTS - 1));
  assign pt_x = ox_r;
  assign pt_y = oy_r;

  // Step stays at or above its floor during weights, emits stay within the point budget, and weights see t below one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_WEIGHT) |-> (step_r >= T_W'(MIN_STEP)))
    else $error("step below minimum");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> (n_r < CNT_W'(MAX_POINTS - 1)))
    else $error("point budget exceeded");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_WEIGHT) |-> (t_r < T_W'(17'h10000)))
    else $error("weights computed for t at or above one");

endmodule

FILE: rtl/core/cbf_ctrl.sv
// Controller state machine sequencing the flattener datapath.
`timescale 1ns / 1ps
module cbf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cbf_pkg::dp_stat_t  stat,
  output cbf_pkg::dp_cmd_t   cmd,
  output logic               out_valid,
  output logic               out_last
);
  import cbf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SQRT   = 8'b0000_0010,
    S_DIV    = 8'b0000_0100,
    S_WEIGHT = 8'b0000_1000,
    S_ACC    = 8'b0001_0000,
    S_EMIT   = 8'b0010_0000,
    S_END    = 8'b0100_0000,
    S_SHOW   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   first_r, first_nxt;
  logic   valid_r, valid_nxt;
  logic   last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    first_nxt = 1'b0;
    valid_nxt = 1'b0;
    last_nxt  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.first = first_r;
    unique case (state_r)
      S_IDLE: begin
        // the end point strobe still shows on the first idle cycle
        if (start && !busy) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_SQRT;
          first_nxt = 1'b1;
        end
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (stat.done) begin
          state_nxt = S_DIV;
          first_nxt = 1'b1;
        end
      end
      S_DIV: begin
        if (!first_r && stat.chord_zero) state_nxt = S_END;
        else begin
          cmd.op = OP_DIV;
          if (stat.done) begin
            state_nxt = S_SHOW;
          end
        end
      end
      S_SHOW: begin
        // decide whether another interior point follows
        if (stat.t_more) begin
          state_nxt = S_WEIGHT;
          first_nxt = 1'b1;
        end else state_nxt = S_END;
      end
      S_WEIGHT: begin
        cmd.op = OP_WEIGHT;
        if (stat.done) begin
          state_nxt = S_ACC;
          first_nxt = 1'b1;
        end
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (stat.done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.op    = OP_EMIT;
        valid_nxt = 1'b1;
        state_nxt = S_SHOW;
      end
      S_END: begin
        cmd.op    = OP_END;
        valid_nxt = 1'b1;
        last_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b0;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE) || valid_r;
  assign out_valid = valid_r;
  assign out_last  = last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_SQRT))
    else $error("accepted segment did not start the root");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("last flag without a strobe");
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_last) |-> (state_r == S_IDLE))
    else $error("segment continued past its end point");

endmodule

FILE: rtl/core/cubic_bezier_flattener_unit.sv
// Top level of the cubic Bezier flattener.
`timescale 1ns / 1ps
// Takes one cubic segment per start beat (accepted when start is high and
// busy low) and emits curve points on out_valid, one cycle each; the receiver
// cannot stall, so each beat must be taken when shown. A segment runs a load,
// a bit-serial square root (one result bit per cycle), a bit-serial divide
// for the step (a setup step, then 32 quotient bits, one per cycle) and a
// decide step; then, per interior point, the weights on the shared multiplier,
// accumulate, emit and decide; then the end point and its strobe. busy stays
// high throughout, so the next start is taken only after that strobe; there
// are at most 63 interior points. A zero chord skips the divide iterations
// and the points. cfg_we writes step_resolution; write it only while idle.
// A zero chord gives the end point alone.
module cubic_bezier_flattener_unit #(
  parameter int MAX_POINTS  = cbf_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  cbf_pkg::in_beat_t             in_beat,
  output logic                          out_valid,
  output cbf_pkg::out_beat_t            out_beat,
  input  logic                          cfg_we,
  input  logic [cbf_pkg::RES_W-1:0]     cfg_wdata
);
  import cbf_pkg::*;

  logic [RES_W-1:0]     step_res_r;
  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic                 last;
  logic signed [COORD_WIDTH_DEF-1:0] px, py;

  always_ff @(posedge clk) begin
    if (!rst_n) step_res_r <= RES_RESET;
    else if (cfg_we) step_res_r <= cfg_wdata;
  end

  cbf_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .stat, .cmd,
    .out_valid, .out_last(last)
  );

  cbf_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk, .rst_n, .in_beat, .step_res(step_res_r), .cmd, .stat,
    .pt_x(px), .pt_y(py)
  );

  always_comb begin
    out_beat            = '0;
    out_beat.point_x    = px;
    out_beat.point_y    = py;
    out_beat.last_point = last;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");
  // every point strobe lasts a single cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("point strobe held for two cycles");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_beat.last_point |-> out_valid)
    else $error("last point flag without a strobe");

endmodule

FILE: dv/cubic_bezier_flattener_unit_tb.sv
// Self-checking testbench for the cubic Bezier flattener top level.
`timescale 1ns / 1ps
module cubic_bezier_flattener_unit_tb;
  import cbf_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int NPTS = MAX_POINTS_DEF;
  localparam longint ONE_T = 65536;
  localparam int TAIL_CYCLES = 1200;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_beat_t in_beat;
  logic out_valid;
  out_beat_t out_beat;
  logic cfg_we;
  logic [RES_W-1:0] cfg_wdata;

  // predictor copy of the step register
  logic [RES_W-1:0] spacing_q;
  out_beat_t point_queue[$];
  int n_errors;
  bit idle_en;

  cubic_bezier_flattener_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_valid(out_valid), .out_beat(out_beat), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("cubic_bezier_flattener_unit_tb: done, errors");
    $finish;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] sat_coord(longint v);
    longint hi;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[CW-1:0];
  endfunction

  function automatic longint unsigned abs_capped(longint a, longint b);
    longint d;
    longint unsigned m;
    d = b - a;
    m = (d < 0) ? -d : d;
    return (m > (64'd1 << 22)) ? (64'd1 << 22) : m;
  endfunction

  // blend four control coordinates with Q0.24 weights, round half up
  function automatic logic [CW-1:0] blend(longint unsigned w[4], longint p[4]);
    longint acc;
    longint unsigned biased;
    acc = 0;
    for (int i = 0; i < 4; i++) acc += longint'(w[i]) * p[i];
    biased = longint'(acc) + (64'd1 << 56) + (64'd1 << 23);
    return sat_coord(longint'(biased >> 24) - (longint'(1) <<< 32));
  endfunction

  task automatic flatten_segment(input in_beat_t seg);
    longint px[4], py[4];
    longint unsigned dx, dy, chord, stp, t, u;
    longint unsigned w[4];
    out_beat_t pt;
    int n;
    px = '{longint'(seg.start_x), longint'(seg.ctrl1_x), longint'(seg.ctrl2_x),
           longint'(seg.end_x)};
    py = '{longint'(seg.start_y), longint'(seg.ctrl1_y), longint'(seg.ctrl2_y),
           longint'(seg.end_y)};
    dx = abs_capped(px[0], px[3]);
    dy = abs_capped(py[0], py[3]);
    chord = isqrt(dx * dx + dy * dy);
    n = 0;
    if (chord != 0) begin
      stp = (longint'(spacing_q) << 16) / chord;
      if (stp < (ONE_T + NPTS - 1) / NPTS) stp = (ONE_T + NPTS - 1) / NPTS;
      for (t = stp; t < ONE_T && n < NPTS - 1; t += stp) begin
        u = ONE_T - t;
        w[0] = u * u * u;
        w[1] = 3 * u * u * t;
        w[2] = 3 * u * t * t;
        w[3] = t * t * t;
        for (int i = 0; i < 4; i++) w[i] = (w[i] + (64'd1 << 23)) >> 24;
        pt.point_x = blend(w, px);
        pt.point_y = blend(w, py);
        pt.last_point = 1'b0;
        point_queue = {point_queue, pt};
        n++;
      end
    end
    pt.point_x = sat_coord(px[3]);
    pt.point_y = sat_coord(py[3]);
    pt.last_point = 1'b1;
    point_queue = {point_queue, pt};
  endtask

  // result checker: receiver never stalls
  always @(posedge clk) begin
    out_beat_t exp_pt;
    if (rst_n && out_valid) begin
      if (point_queue.size() == 0) begin
        $error("unexpected beat x=%0d y=%0d", out_beat.point_x, out_beat.point_y);
        n_errors++;
      end else begin
        exp_pt = point_queue.pop_front();
        if (out_beat.point_x !== exp_pt.point_x) begin
          $error("point_x exp %0d got %0d", exp_pt.point_x, out_beat.point_x);
          n_errors++;
        end
        if (out_beat.point_y !== exp_pt.point_y) begin
          $error("point_y exp %0d got %0d", exp_pt.point_y, out_beat.point_y);
          n_errors++;
        end
        if (out_beat.last_point !== exp_pt.last_point) begin
          $error("last_point exp %0b got %0b", exp_pt.last_point,
                 out_beat.last_point);
          n_errors++;
        end
      end
    end
  end

  task automatic send_segment(input in_beat_t seg);
    @(posedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_beat <= seg;
    @(posedge clk);
    while (busy) @(posedge clk);
    flatten_segment(seg);
    start <= 1'b0;
  endtask

  task automatic drain;
    while (point_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_spacing(input logic [RES_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    spacing_q = val;
  endtask

  function automatic in_beat_t mk_seg(longint sx, longint sy, longint c1x, longint c1y,
                                      longint c2x, longint c2y, longint ex, longint ey);
    in_beat_t s;
    s.start_x = CW'(sx); s.start_y = CW'(sy);
    s.ctrl1_x = CW'(c1x); s.ctrl1_y = CW'(c1y);
    s.ctrl2_x = CW'(c2x); s.ctrl2_y = CW'(c2y);
    s.end_x = CW'(ex); s.end_y = CW'(ey);
    return s;
  endfunction

  function automatic logic signed [CW-1:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return CW'($urandom());
      1: return CW'($signed(CW'($urandom_range(0, 8191))) - 4096);
      2: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      default: return CW'($signed(CW'($urandom_range(0, 262143))) - 131072);
    endcase
  endfunction

  function automatic in_beat_t rnd_segment();
    in_beat_t s;
    s = $urandom_range(0, 1) ? {$urandom(), $urandom(), $urandom(), $urandom(),
                                $urandom(), $urandom()} : '0;
    s.start_x = rnd_coord(); s.start_y = rnd_coord();
    s.ctrl1_x = rnd_coord(); s.ctrl1_y = rnd_coord();
    s.ctrl2_x = rnd_coord(); s.ctrl2_y = rnd_coord();
    s.end_x = rnd_coord(); s.end_y = rnd_coord();
    // keep many segments short so the step is above its floor
    if ($urandom_range(0, 2) == 0) begin
      s.end_x = CW'(s.start_x + $signed(CW'($urandom_range(0, 4095))) - 2048);
      s.end_y = CW'(s.start_y + $signed(CW'($urandom_range(0, 4095))) - 2048);
    end
    return s;
  endfunction

  task automatic test_directed;
    in_beat_t s;
    logic signed [CW-1:0] mx, mn;
    longint lx, ln;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    lx = longint'(mx);
    ln = longint'(mn);
    s = '0;
    send_segment(s);                                // zero chord
    s = mk_seg(0, 0, 256, 0, 512, 0, 768, 0);       // straight line, 3 px
    send_segment(s);
    s = mk_seg(0, 0, 0, 0, 0, 0, 100, 0);           // step of one or more
    send_segment(s);
    s = mk_seg(ln, ln, lx, ln, ln, lx, lx, lx);     // long chord, saturation
    send_segment(s);
    s = mk_seg(lx, lx, lx, lx, lx, lx, lx, lx);
    send_segment(s);
    s = mk_seg(ln, ln, ln, ln, ln, ln, ln, ln);
    send_segment(s);
    s = mk_seg(lx, ln, ln, lx, lx, ln, ln, lx);     // overshoot near range ends
    send_segment(s);
    s = mk_seg(-1000, 2000, 5000, -7000, 9000, 3000, 12000, -4000);
    send_segment(s);
    s = mk_seg(0, 0, 0, 0, 0, 0, 1, 1);             // tiny chord
    send_segment(s);
    s = mk_seg(-1, -1, -1, -1, -1, -1, -1, -1);
    send_segment(s);
  endtask

  task automatic test_spacing_sweep;
    logic [RES_W-1:0] vals[5] = '{16'd1, 16'd65535, 16'd0, 16'd64, 16'd4096};
    foreach (vals[i]) begin
      write_spacing(vals[i]);
      repeat (3) send_segment(rnd_segment());
    end
    write_spacing(RES_RESET);
  endtask

  task automatic test_random;
    for (int i = 0; i < 445; i++) begin
      if (i == 380) idle_en = 1'b0;
      if (i % 90 == 89) write_spacing($urandom_range(0, 3) == 0 ?
                                      RES_W'($urandom()) :
                                      RES_W'($urandom_range(16, 2048)));
      send_segment(rnd_segment());
    end
  endtask

  initial begin
    n_errors = 0;
    idle_en = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_beat = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    spacing_q = RES_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();                                         // sender holds off
    test_spacing_sweep();
    test_random();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0 && point_queue.size() == 0) begin
      $display("cubic_bezier_flattener_unit_tb: done, clean");
    end else begin
      $display("cubic_bezier_flattener_unit_tb: done, errors");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/core/cbf_pkg.sv
rtl/core/cbf_datapath.sv
rtl/core/cbf_ctrl.sv
rtl/core/cubic_bezier_flattener_unit.sv
dv/cubic_bezier_flattener_unit_tb.sv
